// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the angle-tracking loop.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_SAME(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("next-cycle check failed");

`endif

// ===== src/atpv_pkg.sv =====
// Package for the angle-tracking loop: field widths, register reset values,
// register indexes, sequencer states and the multiplier operand type. No dependencies.
package atpv_pkg;

  localparam int unsigned AngleW   = 32;
  localparam int unsigned VelW     = 32;
  localparam int unsigned PeriodW  = 32;
  localparam int unsigned PropW    = 31;
  localparam int unsigned IntegW   = 32;
  localparam int unsigned SnapW    = 31;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned MulOpW   = 33;
  localparam int unsigned ProdW    = 64;

  localparam logic [PeriodW-1:0] SamplePeriodRst = 32'd4294967;
  localparam logic [PropW-1:0]   PropGainRst     = 31'd214748365;
  localparam logic [IntegW-1:0]  IntegGainRst    = 32'd655360;
  localparam logic [SnapW-1:0]   SnapBandRst     = 31'd0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SAMPLE_PERIOD = 3'd0,
    REG_PROP_GAIN     = 3'd1,
    REG_INTEG_GAIN    = 3'd2,
    REG_SNAP_BAND     = 3'd3
  } atpv_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULV,
    ST_ERR,
    ST_MULP,
    ST_MULI,
    ST_FIN,
    ST_EMIT
  } atpv_state_t;

  typedef struct packed {
    logic signed [MulOpW-1:0] a;
    logic signed [MulOpW-1:0] b;
  } atpv_mul_op_t;

endpackage

// ===== src/atpv_if.sv =====
// Valid/ready channel interfaces for the angle-tracking loop's input and result items.
// Depends on atpv_pkg for field widths.
interface atpv_in_if;
  logic                          valid;
  logic                          ready;
  logic [atpv_pkg::AngleW-1:0]   measured_angle;
  logic                          enabled;

  modport source (output valid, output measured_angle, output enabled, input ready);
  modport sink   (input valid, input measured_angle, input enabled, output ready);
endinterface

interface atpv_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [atpv_pkg::VelW-1:0]   velocity_est;
  logic [atpv_pkg::AngleW-1:0]        angle_est;

  modport source (output valid, output velocity_est, output angle_est, input ready);
  modport sink   (input valid, input velocity_est, input angle_est, output ready);
endinterface

// ===== src/atpv_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on atpv_pkg for the operand type and product width.
module atpv_mul (
  input  logic                                 clk,
  input  atpv_pkg::atpv_mul_op_t               op,
  output logic signed [atpv_pkg::ProdW-1:0]    prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= atpv_pkg::ProdW'(op.a * op.b);
  end

endmodule

// ===== src/angle_tracking_pll_velocity.sv =====
// Top level of the angle-tracking loop velocity estimator.
// Depends on atpv_pkg, atpv_if, atpv_mul and assert_macros.svh.
//
// Usage:
//   in_itf carries one item per sample: measured_angle (binary angle, 2^32 is
//   one turn) and enabled. out_itf returns exactly one result item per input
//   item: velocity_est (signed Q16.16 rev/s) and angle_est (binary angle).
//   cfg_we/cfg_index/cfg_wdata write sample_period (0), prop_gain_dt (1),
//   integ_gain_dt (2) and zero_snap_band (3); other indexes are ignored.
//   Write configuration only while the block is idle.
// Sequencing:
//   A tracking item walks a sequencer through one registered 33x33 signed
//   multiplier used three times (velocity*dt, error*kp, error*ki), in states
//   MULV, ERR, MULP, MULI and FIN. The result is loaded as FIN is left, at the
//   same edge that raises ready; no new item is taken before then. Disabled
//   items and items with a zero sample period skip the multiplier (EMIT).
// Reset (synchronous, rst_n low): registers take their reset values, the
//   estimates clear to zero and tracking stops.
// Stall: one output register holds the result item; while it is still full
//   and out_itf.ready is low the sequencer holds its last step, and a new
//   item can be accepted while a finished one waits.
`include "assert_macros.svh"

module angle_tracking_pll_velocity (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [atpv_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [atpv_pkg::CfgDataW-1:0]     cfg_wdata,
  atpv_in_if.sink                           in_itf,
  atpv_out_if.source                        out_itf
);

  // Configuration registers
  logic [atpv_pkg::PeriodW-1:0] sample_period_r;
  logic [atpv_pkg::PropW-1:0]   prop_gain_r;
  logic [atpv_pkg::IntegW-1:0]  integ_gain_r;
  logic [atpv_pkg::SnapW-1:0]   snap_band_r;

  // Loop state and working registers
  atpv_pkg::atpv_state_t             state_r, state_nxt;
  logic [atpv_pkg::AngleW-1:0]       angle_r, angle_nxt;
  logic signed [atpv_pkg::VelW-1:0]  vel_r, vel_nxt;
  logic                              track_r, track_nxt;
  logic [atpv_pkg::AngleW-1:0]       meas_r, meas_nxt;
  logic [atpv_pkg::AngleW-1:0]       pred_r, pred_nxt;
  logic signed [atpv_pkg::AngleW-1:0] err_r, err_nxt;

  // Output register
  logic                              out_valid_r, out_valid_nxt;
  logic signed [atpv_pkg::VelW-1:0]  out_vel_r, out_vel_nxt;
  logic [atpv_pkg::AngleW-1:0]       out_angle_r, out_angle_nxt;

  // Shared multiplier
  atpv_pkg::atpv_mul_op_t               mul_op;
  logic signed [atpv_pkg::ProdW-1:0]    prod_r;

  // Rounding adder: a single adder, offset chosen by the shift of each step
  logic signed [atpv_pkg::ProdW:0]      rnd_off;
  logic signed [atpv_pkg::ProdW:0]      rnd_sum;

  logic                              accept;
  logic                              slot_free;
  logic [atpv_pkg::AngleW-1:0]       pred_c;
  logic signed [atpv_pkg::VelW+1:0]  vsum;
  logic signed [atpv_pkg::VelW-1:0]  vsat;
  logic [atpv_pkg::VelW-1:0]         vmag;

  assign in_itf.ready         = (state_r == atpv_pkg::ST_IDLE);
  assign accept               = in_itf.valid && in_itf.ready;
  assign slot_free            = !out_valid_r || out_itf.ready;
  assign out_itf.valid        = out_valid_r;
  assign out_itf.velocity_est = out_vel_r;
  assign out_itf.angle_est    = out_angle_r;

  // Configuration writes; unknown indexes drop silently
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_period_r <= atpv_pkg::SamplePeriodRst;
      prop_gain_r     <= atpv_pkg::PropGainRst;
      integ_gain_r    <= atpv_pkg::IntegGainRst;
      snap_band_r     <= atpv_pkg::SnapBandRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        atpv_pkg::REG_SAMPLE_PERIOD: sample_period_r <= cfg_wdata;
        atpv_pkg::REG_PROP_GAIN:     prop_gain_r     <= cfg_wdata[atpv_pkg::PropW-1:0];
        atpv_pkg::REG_INTEG_GAIN:    integ_gain_r    <= cfg_wdata;
        atpv_pkg::REG_SNAP_BAND:     snap_band_r     <= cfg_wdata[atpv_pkg::SnapW-1:0];
        default: ;
      endcase
    end
  end

  // Multiplier operands: velocity*dt first, then error times each gain
  always_comb begin
    unique case (state_r)
      atpv_pkg::ST_MULV: begin
        mul_op.a = {vel_r[atpv_pkg::VelW-1], vel_r};
        mul_op.b = {1'b0, sample_period_r};
      end
      atpv_pkg::ST_MULP: begin
        mul_op.a = {err_r[atpv_pkg::AngleW-1], err_r};
        mul_op.b = {2'b00, prop_gain_r};
      end
      default: begin
        mul_op.a = {err_r[atpv_pkg::AngleW-1], err_r};
        mul_op.b = {1'b0, integ_gain_r};
      end
    endcase
  end

  atpv_mul u_mul (
    .clk    (clk),
    .op     (mul_op),
    .prod_r (prod_r)
  );

  // Round to nearest, ties up: add half an output LSB, then floor shift
  always_comb begin
    unique case (state_r)
      atpv_pkg::ST_ERR:  rnd_off = (atpv_pkg::ProdW+1)'(1) <<< 15;
      atpv_pkg::ST_MULI: rnd_off = (atpv_pkg::ProdW+1)'(1) <<< 29;
      default:           rnd_off = (atpv_pkg::ProdW+1)'(1) <<< 31;
    endcase
    rnd_sum = {prod_r[atpv_pkg::ProdW-1], prod_r} + rnd_off;
  end

  // Prediction and velocity update datapath
  always_comb begin
    pred_c = angle_r + rnd_sum[47:16];
    vsum   = {{2{vel_r[atpv_pkg::VelW-1]}}, vel_r}
           + {rnd_sum[atpv_pkg::ProdW], rnd_sum[atpv_pkg::ProdW:32]};
    // Saturate to the signed 32-bit range
    if (vsum[33:31] != 3'b000 && vsum[33:31] != 3'b111) begin
      vsat = vsum[33] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      vsat = vsum[31:0];
    end
    vmag = vsat[atpv_pkg::VelW-1] ? (32'd0 - vsat) : vsat;
  end

  // Sequencer: next state and working registers
  always_comb begin
    state_nxt     = state_r;
    angle_nxt     = angle_r;
    vel_nxt       = vel_r;
    track_nxt     = track_r;
    meas_nxt      = meas_r;
    pred_nxt      = pred_r;
    err_nxt       = err_r;
    out_vel_nxt   = out_vel_r;
    out_angle_nxt = out_angle_r;
    out_valid_nxt = out_itf.ready ? 1'b0 : out_valid_r;

    unique case (state_r)
      atpv_pkg::ST_IDLE: begin
        if (accept) begin
          meas_nxt = in_itf.measured_angle;
          priority if (sample_period_r == '0) begin
            // Zero period: clear velocity, keep angle and tracking
            vel_nxt   = '0;
            state_nxt = atpv_pkg::ST_EMIT;
          end else if (!in_itf.enabled) begin
            // Disabled: follow the measurement and drop tracking
            angle_nxt = in_itf.measured_angle;
            vel_nxt   = '0;
            track_nxt = 1'b0;
            state_nxt = atpv_pkg::ST_EMIT;
          end else begin
            // First enabled item seeds the estimate
            if (!track_r) begin
              angle_nxt = in_itf.measured_angle;
              vel_nxt   = '0;
              track_nxt = 1'b1;
            end
            state_nxt = atpv_pkg::ST_MULV;
          end
        end
      end
      atpv_pkg::ST_MULV: state_nxt = atpv_pkg::ST_ERR;
      atpv_pkg::ST_ERR: begin
        // Wrapped error is the 32-bit difference read as signed
        pred_nxt  = pred_c;
        err_nxt   = meas_r - pred_c;
        state_nxt = atpv_pkg::ST_MULP;
      end
      atpv_pkg::ST_MULP: state_nxt = atpv_pkg::ST_MULI;
      atpv_pkg::ST_MULI: begin
        angle_nxt = pred_r + rnd_sum[61:30];
        state_nxt = atpv_pkg::ST_FIN;
      end
      atpv_pkg::ST_FIN: begin
        // Hold here until the output register can take the item
        if (slot_free) begin
          vel_nxt       = (vmag < {1'b0, snap_band_r}) ? '0 : vsat;
          out_vel_nxt   = (vmag < {1'b0, snap_band_r}) ? '0 : vsat;
          out_angle_nxt = angle_r;
          out_valid_nxt = 1'b1;
          state_nxt     = atpv_pkg::ST_IDLE;
        end
      end
      atpv_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_vel_nxt   = vel_r;
          out_angle_nxt = angle_r;
          out_valid_nxt = 1'b1;
          state_nxt     = atpv_pkg::ST_IDLE;
        end
      end
      default: state_nxt = atpv_pkg::ST_IDLE;
    endcase
  end

  // Control and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= atpv_pkg::ST_IDLE;
      angle_r     <= '0;
      vel_r       <= '0;
      track_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      angle_r     <= angle_nxt;
      vel_r       <= vel_nxt;
      track_r     <= track_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    meas_r      <= meas_nxt;
    pred_r      <= pred_nxt;
    err_r       <= err_nxt;
    out_vel_r   <= out_vel_nxt;
    out_angle_r <= out_angle_nxt;
  end

  // A disabled item with a nonzero period always drops tracking
  `ASSERT_NEXT(a_disable_clears_track, clk, rst_n,
    accept && !in_itf.enabled && (sample_period_r != '0), !track_r)

  // A zero period always leaves the velocity cleared
  `ASSERT_NEXT(a_zero_period_clears_vel, clk, rst_n,
    accept && (sample_period_r == '0), vel_r == '0)

  // A result is only loaded from one of the two final steps
  `ASSERT_SAME(a_load_from_final_step, clk, rst_n, out_valid_r && !$past(out_valid_r),
    $past(state_r) == atpv_pkg::ST_FIN || $past(state_r) == atpv_pkg::ST_EMIT)

endmodule

// ===== dv/angle_tracking_pll_velocity_tb.sv =====
// Self-checking testbench for the angle-tracking loop velocity estimator.
// Depends on atpv_pkg, atpv_if and the angle_tracking_pll_velocity RTL.
`timescale 1ns / 1ps

module angle_tracking_pll_velocity_tb;
  import atpv_pkg::*;

  localparam int unsigned ClkHalf       = 5;
  localparam int unsigned ResetCycles   = 4;
  // Longest item through the sequencer, plus margin for the output register.
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandPhases    = 8;
  localparam int unsigned PhaseItems    = 68;
  localparam int unsigned RegIdxMax     = (1 << CfgIdxW) - 1;

  // Scoreboard: a bit-exact copy of the tracking loop plus the queue of
  // estimates still owed by the block.
  class est_scoreboard;
    localparam longint VelMax = 64'sd2147483647;
    localparam longint VelMin = -64'sd2147483648;

    typedef struct {
      logic signed [VelW-1:0] vel;
      logic [AngleW-1:0]      ang;
    } estimate_t;

    logic [PeriodW-1:0]     period;
    logic [PropW-1:0]       kp_dt;
    logic [IntegW-1:0]      ki_dt;
    logic [SnapW-1:0]       snap_band;
    logic [AngleW-1:0]      angle_q;
    logic signed [VelW-1:0] vel_q;
    bit                     tracking;
    estimate_t              estimates_due[$];
    int                     errors;

    function new();
      period    = SamplePeriodRst;
      kp_dt     = PropGainRst;
      ki_dt     = IntegGainRst;
      snap_band = SnapBandRst;
      angle_q   = '0;
      vel_q     = '0;
      tracking  = 1'b0;
      errors    = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_SAMPLE_PERIOD: period    = val[PeriodW-1:0];
        REG_PROP_GAIN:     kp_dt     = val[PropW-1:0];
        REG_INTEG_GAIN:    ki_dt     = val[IntegW-1:0];
        REG_SNAP_BAND:     snap_band = val[SnapW-1:0];
        default: ;
      endcase
    endfunction

    // Round to nearest, ties toward plus infinity: add half, floor shift.
    function longint round_shift(longint x, int unsigned n);
      return (x + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function void note_sample(logic [AngleW-1:0] meas, logic en);
      logic [AngleW-1:0]      pred;
      logic signed [VelW-1:0] err;
      longint                 t;
      longint                 v;
      longint                 mag;
      estimate_t              e;
      if (period == '0) begin
        vel_q = '0;
      end else if (!en) begin
        angle_q  = meas;
        vel_q    = '0;
        tracking = 1'b0;
      end else begin
        if (!tracking) begin
          angle_q  = meas;
          vel_q    = '0;
          tracking = 1'b1;
        end
        t    = round_shift(longint'(vel_q) * $signed({32'd0, period}), 16);
        pred = angle_q + t[AngleW-1:0];
        err  = meas - pred;
        t    = round_shift(longint'(err) * $signed({33'd0, kp_dt}), 30);
        angle_q = pred + t[AngleW-1:0];
        v = longint'(vel_q) + round_shift(longint'(err) * $signed({32'd0, ki_dt}), 32);
        if (v > VelMax) v = VelMax;
        if (v < VelMin) v = VelMin;
        mag = (v < 0) ? -v : v;
        if (mag < $signed({33'd0, snap_band})) v = 0;
        vel_q = v[VelW-1:0];
      end
      e.vel = en ? vel_q : '0;
      e.ang = angle_q;
      estimates_due.push_back(e);
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      $display("[%0t] mismatch on %s: got %h, want %h", $realtime, field, got, want);
      errors++;
    endtask

    task check_estimate(logic signed [VelW-1:0] vel, logic [AngleW-1:0] ang);
      estimate_t e;
      if (estimates_due.size() == 0) begin
        report("unrequested velocity_est", vel, '0);
        return;
      end
      e = estimates_due.pop_front();
      if (vel !== e.vel) report("velocity_est", vel, e.vel);
      if (ang !== e.ang) report("angle_est", ang, e.ang);
    endtask

    function int pending();
      return estimates_due.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;
  int                  idle_pct;
  int                  stall_left = 0;

  atpv_in_if  in_itf ();
  atpv_out_if out_itf ();

  est_scoreboard sb = new();

  angle_tracking_pll_velocity i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_itf    (in_itf),
    .out_itf   (out_itf)
  );

  always begin
    clk = 1'b0;
    #(ClkHalf);
    clk = 1'b1;
    #(ClkHalf);
  end

  // Result side: stall in random bursts while the phase asks for idling,
  // otherwise keep ready high.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_itf.ready <= 1'b0;
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 11);
      out_itf.ready <= 1'b0;
    end else begin
      out_itf.ready <= 1'b1;
    end
  end

  // Check every result item against the oldest owed estimate.
  always @(posedge clk) begin
    if (rst_n && out_itf.valid && out_itf.ready) begin
      sb.check_estimate(out_itf.velocity_est, out_itf.angle_est);
    end
  end

  // Offer one sample, optionally after an idle burst, and hold it until the
  // block takes it. Leave valid high so back-to-back items need no gap.
  task automatic send_sample(input logic [AngleW-1:0] angle, input logic en);
    int gap;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 12);
      in_itf.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_itf.valid          <= 1'b1;
    in_itf.measured_angle <= angle;
    in_itf.enabled        <= en;
    @(posedge clk);
    while (!in_itf.ready) @(posedge clk);
    sb.note_sample(angle, en);
  endtask

  // Drop valid and wait until every owed estimate has come back, then let
  // the sequencer settle before anything touches the registers.
  task automatic drain();
    in_itf.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Leave cfg_we high; the caller lowers it once after the last write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_config(input logic [31:0] period, input logic [31:0] kp,
                              input logic [31:0] ki, input logic [31:0] snap,
                              input bit stray_write);
    write_reg(REG_SAMPLE_PERIOD, period);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_SNAP_BAND, snap);
    // An index past the register list must leave everything as it was.
    if (stray_write) begin
      write_reg(CfgIdxW'($urandom_range(int'(REG_SNAP_BAND) + 1, RegIdxMax)), $urandom());
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_edge(logic [31:0] lo, logic [31:0] hi);
    case ($urandom_range(0, 2))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  initial begin : stimulus
    logic [31:0] period;
    logic [31:0] kp;
    logic [31:0] ki;
    logic [31:0] snap;
    logic [31:0] true_ang;
    logic [31:0] speed;
    int signed   noise;
    int          roll;
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_index             <= REG_SAMPLE_PERIOD;
    cfg_wdata             <= '0;
    in_itf.valid          <= 1'b0;
    in_itf.measured_angle <= '0;
    in_itf.enabled        <= 1'b0;
    idle_pct              <= 0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration: disabled samples at the angle extremes, seeding,
    // a half-turn jump, disable while tracking, reseed, error at both ends.
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h1234_5678, 1'b1);
    send_sample(32'h1334_5678, 1'b1);
    send_sample(32'h1434_5678, 1'b1);
    send_sample(32'h9434_5678, 1'b1);
    send_sample(32'h1434_0000, 1'b1);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 1'b1);
    send_sample(32'h8000_0000, 1'b1);
    send_sample(32'h7FFF_FFFF, 1'b1);

    // Longest period, proportional gain above one, full integral gain:
    // drive the velocity into saturation. Stay tracking on exit.
    drain();
    apply_config(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    send_sample(32'h7FFF_FFFF, 1'b1);
    send_sample(32'h8000_0000, 1'b1);
    send_sample(32'h7FFF_FFFF, 1'b1);
    send_sample(32'h0000_0000, 1'b1);
    send_sample(32'hC000_0000, 1'b1);

    // Zero sample period: velocity clears, angle and tracking are kept.
    drain();
    apply_config(32'h0000_0000, 32'h4000_0000, 32'h0001_0000, 32'h7FFF_FFFF, 1'b0);
    send_sample(32'hDEAD_BEEF, 1'b1);
    send_sample(32'h0123_4567, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1);

    // Shortest period, zero gains, widest snap band.
    drain();
    apply_config(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1);
    send_sample(32'h4000_0000, 1'b1);
    send_sample(32'hC000_0000, 1'b1);
    send_sample(32'h0000_0001, 1'b0);
    send_sample(32'hFFFF_FFFE, 1'b1);

    // Random phases: even ones look like a real drive, odd ones push the
    // registers to their edges. The last phase runs without idling.
    for (int p = 0; p < RandPhases; p++) begin
      drain();
      if (p % 2 == 0) begin
        period = $urandom_range(42949673, 429497);
        kp     = $urandom_range(32'h4000_0000, 0);
        ki     = $urandom_range(200 << 16, 0);
        snap   = $urandom_range(1 << 14, 0);
      end else begin
        period = ($urandom_range(0, 4) == 0) ? 32'h0 : pick_edge(32'h1, 32'hFFFF_FFFF);
        kp     = pick_edge(32'h0, 32'h7FFF_FFFF);
        ki     = pick_edge(32'h0, 32'hFFFF_FFFF);
        case ($urandom_range(0, 3))
          0:       snap = 32'h7FFF_FFFF;
          1:       snap = $urandom_range(1 << 20, 0);
          default: snap = 32'h0;
        endcase
      end
      apply_config(period, kp, ki, snap, (p % 3) == 0);
      idle_pct <= (p == RandPhases - 1) ? 0 : 15 * $urandom_range(0, 3);

      true_ang = $urandom();
      speed    = $urandom_range(1 << 27, 0);
      if ($urandom_range(0, 1) == 1) speed = -speed;
      for (int k = 0; k < PhaseItems; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 82) begin
          // Follow a moving rotor with measurement noise of random size.
          true_ang += speed;
          noise = int'($urandom()) >>> (32 - $urandom_range(1, 24));
          send_sample(true_ang + noise, 1'b1);
          if ($urandom_range(0, 19) == 0) begin
            speed = $urandom_range(1 << 27, 0);
            if ($urandom_range(0, 1) == 1) speed = -speed;
          end
        end else if (roll < 89) begin
          send_sample($urandom(), 1'b0);
        end else if (roll < 94) begin
          true_ang = $urandom();
          send_sample(true_ang, 1'b1);
        end else begin
          send_sample($urandom(), 1'($urandom_range(0, 1)));
        end
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Abort if neither channel moves an item for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_itf.valid && in_itf.ready) || (out_itf.valid && out_itf.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Verification failed");
    $finish;
  end

endmodule
